// File: hw/rtl/sdl_pkg.sv
// Shared types, codes and elaboration-time sigmoid table helpers for the sparse dense layer.
`default_nettype none

package sdl_pkg;

  // Fixed field and datapath widths.
  localparam int COL_W = 10;
  localparam int ACC_W = 48;

  // Q32 value of e^-1, used to scale the exponential by whole units.
  localparam logic [63:0] EXP_M1_Q32 = 64'd1580030169;

  // Input item modes.
  typedef enum logic [1:0] {
    MODE_WEIGHT = 2'd0,
    MODE_BIAS   = 2'd1,
    MODE_ENTRY  = 2'd2,
    MODE_FLUSH  = 2'd3
  } mode_t;

  // Output activation kinds.
  typedef enum logic [1:0] {
    ACT_LINEAR  = 2'd0,
    ACT_RELU    = 2'd1,
    ACT_SIGMOID = 2'd2,
    ACT_LEAKY   = 2'd3
  } act_kind_t;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ACT_KIND   = 2'd0;
  localparam logic [1:0] CFG_LEAKY_GAIN = 2'd1;
  localparam logic [1:0] CFG_OUT_COUNT  = 2'd2;

  // One input item.
  typedef struct packed {
    mode_t              mode;
    logic [5:0]         out_row;
    logic [9:0]         column_index;
    logic signed [15:0] weight_value;
    logic signed [31:0] bias_value;
    logic signed [15:0] feature_value;
    logic               last_entry;
  } in_item_t;

  // One result item.
  typedef struct packed {
    logic [5:0]         out_index;
    logic signed [31:0] out_value;
    logic               last_out;
  } out_item_t;

  // Per-pass controls for the multiply-accumulate unit.
  typedef struct packed {
    logic               opening;
    logic               col_ok;
    logic signed [15:0] feat;
  } mac_ctl_t;

  // Status back from the multiply-accumulate unit.
  typedef struct packed {
    logic shift;
    logic done;
  } mac_stat_t;

  // Activation settings.
  typedef struct packed {
    act_kind_t   kind;
    logic [15:0] gain;
  } act_cfg_t;

  // Request to push one accumulator into the activation pipeline.
  typedef struct packed {
    logic       launch;
    logic [5:0] index;
    logic       last;
  } act_req_t;

  // Restoring long division, used only while building constant tables.
  function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
    logic [63:0] q;
    logic [64:0] r;
    q = '0;
    r = '0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[63:0], num[i]};
      if (r >= {1'b0, den}) begin
        r = r - {1'b0, den};
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // e^-t for a Q16.16 argument below 16, returned in Q32.
  function automatic logic [63:0] exp_neg_q32(input logic [31:0] t);
    logic [63:0]        f;
    logic [63:0]        term;
    logic [63:0]        r;
    logic signed [63:0] sum;
    logic [15:0]        n;
    f    = {32'd0, t[15:0], 16'd0};
    n    = t[31:16];
    term = 64'h1_0000_0000;
    sum  = 64'sh1_0000_0000;
    // Taylor series of the fractional part.
    for (int k = 1; k <= 14; k++) begin
      term = udiv64((term * f) >> 32, 64'(k));
      if ((k & 1) == 1) begin
        sum = sum - $signed(term);
      end else begin
        sum = sum + $signed(term);
      end
    end
    if (sum < 0) begin
      r = '0;
    end else begin
      r = $unsigned(sum);
    end
    // Scale by e^-1 once per whole unit.
    for (int k = 0; k < 16; k++) begin
      if (k < int'(n)) begin
        r = (r * EXP_M1_Q32 + 64'h8000_0000) >> 32;
      end
    end
    return r;
  endfunction

  // Sigmoid of the midpoint of bin j out of n bins over [-8,8), in unsigned Q0.16.
  function automatic logic [15:0] sig_entry(input int n, input int j);
    logic [63:0]        xo;
    logic [63:0]        t;
    logic [63:0]        e;
    logic [63:0]        den;
    logic [63:0]        num;
    logic signed [63:0] x;
    xo = udiv64(64'(2 * j + 1) << 20, 64'(2 * n));
    x  = $signed(xo) - 64'sd524288;
    if (x < 0) begin
      t = $unsigned(-x);
    end else begin
      t = $unsigned(x);
    end
    e   = exp_neg_q32(t[31:0]);
    den = 64'h1_0000_0000 + e;
    if (x >= 0) begin
      num = 64'h1_0000_0000_0000;
    end else begin
      num = e << 16;
    end
    return 16'(udiv64(num + (den >> 1), den));
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/sparse_dense_layer_activation.sv
// Top level of the sparse dense layer with output activation.
`default_nettype none

// A dense layer applied to a sparse input vector. Every sparse entry makes one pass in
// which the OUT_DIM accumulators, held in a rotating chain of cells, pass one at a time
// through a single shared multiply-accumulate unit, which is fed by the one read port of
// the weight memory. The first entry of a vector loads the biases in the same pass; a
// flush of a closed vector spends one such pass loading the biases alone. The results
// of a vector then leave at one item per cycle (out_count items, through activation
// stage A, stage B and the output register), slowed only by stall on the result
// channel. There is no clearing pass after reset: the weight and bias stores must be
// written before they are used.
module sparse_dense_layer_activation #(
  parameter int OUT_DIM         = 64,
  parameter int IN_DIM          = 1024,
  parameter int SIGMOID_ENTRIES = 256
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire sdl_pkg::in_item_t in_item,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output sdl_pkg::out_item_t     out_item,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [15:0]       cfg_wdata
);

  localparam int  RW      = (OUT_DIM > 1) ? $clog2(OUT_DIM) : 1;
  localparam int  CW      = (IN_DIM >= 1024) ? sdl_pkg::COL_W
                                             : ((IN_DIM > 1) ? $clog2(IN_DIM) : 1);
  localparam bit  COL_ALL = (IN_DIM >= 1024);
  localparam int  WDEPTH  = OUT_DIM * (2 ** CW);
  localparam int  WAW     = (WDEPTH > 1) ? $clog2(WDEPTH) : 1;
  localparam int  CNTW    = RW + 1;
  localparam int  AW      = sdl_pkg::ACC_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_ACC  = 3'b010,
    ST_EMIT = 3'b100
  } state_t;

  // Configuration registers.
  sdl_pkg::act_kind_t act_kind_r;
  logic [15:0]        gain_r;
  logic [6:0]         count_r;
  logic [6:0]         n_eff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_kind_r <= sdl_pkg::ACT_LINEAR;
      gain_r     <= 16'd0;
      count_r    <= 7'd64;
    end else if (cfg_we) begin
      case (cfg_index)
        sdl_pkg::CFG_ACT_KIND:   act_kind_r <= sdl_pkg::act_kind_t'(cfg_wdata[1:0]);
        sdl_pkg::CFG_LEAKY_GAIN: gain_r     <= cfg_wdata;
        sdl_pkg::CFG_OUT_COUNT:  count_r    <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  // Number of results per vector, with zero acting as one and the top clipped.
  always_comb begin
    if (count_r == 7'd0) begin
      n_eff = 7'd1;
    end else if (count_r > 7'(OUT_DIM)) begin
      n_eff = 7'(OUT_DIM);
    end else begin
      n_eff = count_r;
    end
  end

  // Control state.
  state_t             state_r, state_nxt;
  logic               open_r, open_nxt;
  logic [CNTW-1:0]    iss_r, iss_nxt;
  logic [6:0]         emit_cnt_r, emit_cnt_nxt;

  // Per-pass payload.
  logic [9:0]         col_r, col_nxt;
  logic signed [15:0] feat_r, feat_nxt;
  logic               opening_r, opening_nxt;
  logic               col_ok_r, col_ok_nxt;
  logic               emit_after_r, emit_after_nxt;

  logic               in_acc;
  logic               row_ok;
  logic               col_ok_in;
  logic               w_we;
  logic               b_we;
  logic               issue;
  logic               issue_last;
  logic               emit_launch;
  logic               emit_last;
  logic               act_ready;
  logic               ring_shift;

  logic [15:0]          w_rdata;
  logic [31:0]          b_rdata;
  logic signed [AW-1:0] upd;
  logic signed [AW-1:0] ring [OUT_DIM];

  sdl_pkg::mac_ctl_t  mac_ctl;
  sdl_pkg::mac_stat_t mac_stat;
  sdl_pkg::act_cfg_t  act_cfg;
  sdl_pkg::act_req_t  act_req;

  assign in_stall   = (state_r != ST_IDLE);
  assign in_acc     = in_valid && !in_stall;
  assign row_ok     = {1'b0, in_item.out_row} < 7'(OUT_DIM);
  assign col_ok_in  = COL_ALL || (int'(in_item.column_index) < IN_DIM);
  assign issue      = (state_r == ST_ACC) && (iss_r < CNTW'(OUT_DIM));
  assign issue_last = (iss_r == CNTW'(OUT_DIM - 1));
  assign emit_launch = (state_r == ST_EMIT) && act_ready;
  assign emit_last   = (emit_cnt_r == n_eff - 7'd1);
  assign ring_shift  = mac_stat.shift || emit_launch;

  // Sequencer: memory writes, accumulate passes and result passes.
  always_comb begin
    state_nxt      = state_r;
    open_nxt       = open_r;
    iss_nxt        = iss_r + {{(CNTW - 1){1'b0}}, issue};
    emit_cnt_nxt   = emit_cnt_r + {6'd0, emit_launch};
    col_nxt        = col_r;
    feat_nxt       = feat_r;
    opening_nxt    = opening_r;
    col_ok_nxt     = col_ok_r;
    emit_after_nxt = emit_after_r;
    w_we           = 1'b0;
    b_we           = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          case (in_item.mode)
            sdl_pkg::MODE_WEIGHT: w_we = row_ok && col_ok_in;
            sdl_pkg::MODE_BIAS:   b_we = row_ok;
            sdl_pkg::MODE_ENTRY: begin
              state_nxt      = ST_ACC;
              iss_nxt        = '0;
              open_nxt       = 1'b1;
              opening_nxt    = !open_r;
              col_ok_nxt     = col_ok_in;
              col_nxt        = in_item.column_index;
              feat_nxt       = in_item.feature_value;
              emit_after_nxt = in_item.last_entry;
            end
            sdl_pkg::MODE_FLUSH: begin
              if (open_r) begin
                state_nxt    = ST_EMIT;
                emit_cnt_nxt = 7'd0;
                open_nxt     = 1'b0;
              end else begin
                // A closed vector first loads the biases with nothing added.
                state_nxt      = ST_ACC;
                iss_nxt        = '0;
                open_nxt       = 1'b1;
                opening_nxt    = 1'b1;
                col_ok_nxt     = 1'b0;
                emit_after_nxt = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      ST_ACC: begin
        if (mac_stat.done) begin
          if (emit_after_r) begin
            state_nxt    = ST_EMIT;
            emit_cnt_nxt = 7'd0;
            open_nxt     = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT: begin
        if (emit_launch && emit_last) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      open_r     <= 1'b0;
      iss_r      <= '0;
      emit_cnt_r <= 7'd0;
    end else begin
      state_r    <= state_nxt;
      open_r     <= open_nxt;
      iss_r      <= iss_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    col_r        <= col_nxt;
    feat_r       <= feat_nxt;
    opening_r    <= opening_nxt;
    col_ok_r     <= col_ok_nxt;
    emit_after_r <= emit_after_nxt;
  end

  // Weight store, row-major with the column in the low address bits.
  sdl_ram #(
    .WIDTH (16),
    .DEPTH (WDEPTH)
  ) u_weight_ram (
    .clk   (clk),
    .we    (w_we),
    .waddr (WAW'({in_item.out_row[RW-1:0], in_item.column_index[CW-1:0]})),
    .wdata (in_item.weight_value),
    .raddr (WAW'({iss_r[RW-1:0], col_r[CW-1:0]})),
    .rdata (w_rdata)
  );

  // Bias store.
  sdl_ram #(
    .WIDTH (32),
    .DEPTH (OUT_DIM)
  ) u_bias_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (in_item.out_row[RW-1:0]),
    .wdata (in_item.bias_value),
    .raddr (iss_r[RW-1:0]),
    .rdata (b_rdata)
  );

  // Shared multiply-accumulate between the head and the tail of the chain.
  assign mac_ctl.opening = opening_r;
  assign mac_ctl.col_ok  = col_ok_r;
  assign mac_ctl.feat    = feat_r;

  sdl_mac u_mac (
    .clk        (clk),
    .rst_n      (rst_n),
    .issue      (issue),
    .issue_last (issue_last),
    .ctl        (mac_ctl),
    .w_rdata    (w_rdata),
    .b_rdata    (b_rdata),
    .head       (ring[0]),
    .upd        (upd),
    .stat       (mac_stat)
  );

  // Accumulator chain: each cell hands its value to the one ahead of it.
  for (genvar g = 0; g < OUT_DIM; g++) begin : g_cell
    logic signed [AW-1:0] d_in;
    if (g == OUT_DIM - 1) begin : g_tail
      assign d_in = upd;
    end else begin : g_body
      assign d_in = ring[g + 1];
    end
    sdl_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .shift (ring_shift),
      .d     (d_in),
      .q     (ring[g])
    );
  end

  // Activation and result channel.
  assign act_cfg.kind   = act_kind_r;
  assign act_cfg.gain   = gain_r;
  assign act_req.launch = emit_launch;
  assign act_req.index  = emit_cnt_r[5:0];
  assign act_req.last   = emit_last;

  sdl_act #(
    .SIG_N (SIGMOID_ENTRIES)
  ) u_act (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (act_req),
    .head      (ring[0]),
    .cfg       (act_cfg),
    .ready     (act_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

`ifndef ASSERT_OFF
  // The chain moves for either the accumulator or the result pass, never both.
  a_shift_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !(mac_stat.shift && emit_launch))
    else $error("accumulate and result passes shift the chain together");

  // No more results are launched than the vector calls for.
  a_launch_count: assert property (@(posedge clk) disable iff (!rst_n)
    emit_launch |-> (emit_cnt_r < n_eff))
    else $error("result launched beyond the output count");

  // The accumulate pass only finishes while the sequencer waits for it.
  a_done_in_acc: assert property (@(posedge clk) disable iff (!rst_n)
    mac_stat.done |-> (state_r == ST_ACC))
    else $error("accumulate pass finished outside its state");

  // A vector is closed once its results are being sent.
  a_closed_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) |-> !open_r)
    else $error("vector still open during the result pass");
`endif

endmodule

`default_nettype wire

// File: hw/rtl/sdl_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module sdl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: hw/rtl/sdl_cell.sv
// One accumulator cell of the rotating accumulator chain.
`default_nettype none

module sdl_cell (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              shift,
  input  wire logic signed [sdl_pkg::ACC_W-1:0]  d,
  output logic signed      [sdl_pkg::ACC_W-1:0]  q
);

  logic signed [sdl_pkg::ACC_W-1:0] acc_r;
  logic signed [sdl_pkg::ACC_W-1:0] acc_nxt;

  // Take the neighbor's value whenever the chain moves.
  always_comb begin
    acc_nxt = shift ? d : acc_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r <= '0;
    end else begin
      acc_r <= acc_nxt;
    end
  end

  assign q = acc_r;

endmodule

`default_nettype wire

// File: hw/rtl/sdl_mac.sv
// Shared multiply-accumulate unit that updates the accumulator leaving the head of the chain.
`default_nettype none

module sdl_mac (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              issue,
  input  wire logic                              issue_last,
  input  wire sdl_pkg::mac_ctl_t                 ctl,
  input  wire logic [15:0]                       w_rdata,
  input  wire logic [31:0]                       b_rdata,
  input  wire logic signed [sdl_pkg::ACC_W-1:0]  head,
  output logic signed      [sdl_pkg::ACC_W-1:0]  upd,
  output sdl_pkg::mac_stat_t                     stat
);

  localparam int AW = sdl_pkg::ACC_W;

  logic               v1_r, v1_nxt;
  logic               v2_r, v2_nxt;
  logic               last1_r, last1_nxt;
  logic               last2_r, last2_nxt;
  logic signed [31:0] prod_r, prod_nxt;
  logic signed [31:0] bias_r, bias_nxt;
  logic signed [AW-1:0] base;
  logic signed [AW:0]   sum;

  // Stage one: the memories answer; form the product and hold the bias.
  always_comb begin
    v1_nxt    = issue;
    last1_nxt = issue_last;
    v2_nxt    = v1_r;
    last2_nxt = last1_r;
    bias_nxt  = $signed(b_rdata);
    if (ctl.col_ok) begin
      prod_nxt = $signed(w_rdata) * ctl.feat;
    end else begin
      prod_nxt = 32'sd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= v1_nxt;
      v2_r <= v2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    last1_r <= last1_nxt;
    last2_r <= last2_nxt;
    prod_r  <= prod_nxt;
    bias_r  <= bias_nxt;
  end

  // Stage two: saturating add onto the head value, or onto the bias when a vector opens.
  always_comb begin
    if (ctl.opening) begin
      base = {{(AW - 32){bias_r[31]}}, bias_r};
    end else begin
      base = head;
    end
    sum = {base[AW-1], base} + {{(AW - 31){prod_r[31]}}, prod_r};
    if (sum[AW] != sum[AW-1]) begin
      upd = sum[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
    end else begin
      upd = sum[AW-1:0];
    end
  end

  assign stat.shift = v2_r;
  assign stat.done  = v2_r && last2_r;

endmodule

`default_nettype wire

// File: hw/rtl/sdl_act.sv
// Stallable activation pipeline that turns accumulator values into result items.
`default_nettype none

module sdl_act #(
  parameter int SIG_N = 256
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire sdl_pkg::act_req_t                 req,
  input  wire logic signed [sdl_pkg::ACC_W-1:0]  head,
  input  wire sdl_pkg::act_cfg_t                 cfg,
  output logic                                   ready,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output sdl_pkg::out_item_t                     out_item
);

  localparam int AW  = sdl_pkg::ACC_W;
  localparam int SIW = $clog2(SIG_N);
  localparam int NBW = $clog2(SIG_N + 1);
  localparam int SPW = 20 + NBW;

  // Sigmoid table, one entry per bin over [-8,8).
  logic [15:0] sig_rom [SIG_N];

  for (genvar j = 0; j < SIG_N; j++) begin : g_rom
    localparam logic [15:0] ENTRY = sdl_pkg::sig_entry(SIG_N, j);
    assign sig_rom[j] = ENTRY;
  end

  logic adv;

  // Stage A registers.
  logic                 va_r, va_nxt;
  logic signed [AW-1:0] s_a_r, s_a_nxt;
  logic [AW-1:0]        m_a_r, m_a_nxt;
  logic [5:0]           k_a_r, k_a_nxt;
  logic                 last_a_r, last_a_nxt;

  // Stage B registers.
  logic                 vb_r, vb_nxt;
  logic                 neg_b_r, neg_b_nxt;
  logic                 lo_b_r, lo_b_nxt;
  logic                 hi_b_r, hi_b_nxt;
  logic [31:0]          sat_b_r, sat_b_nxt;
  logic [39:0]          pl_b_r, pl_b_nxt;
  logic [39:0]          ph_b_r, ph_b_nxt;
  logic [SIW-1:0]       idx_b_r, idx_b_nxt;
  logic [5:0]           k_b_r, k_b_nxt;
  logic                 last_b_r, last_b_nxt;

  // Output register.
  logic                 out_valid_r, out_valid_nxt;
  sdl_pkg::out_item_t   out_item_r, out_item_nxt;

  logic [19:0]          u;
  logic [SPW-1:0]       sprod;
  logic [63:0]          p;
  logic [47:0]          q;
  logic [31:0]          leaky_v;
  logic [31:0]          sig_v;
  logic [31:0]          val;

  // The whole pipeline moves when the output register is free or being taken.
  assign adv   = !out_valid_r || !out_stall;
  assign ready = adv;

  // Stage A: capture the head value and its negation.
  always_comb begin
    va_nxt     = req.launch;
    s_a_nxt    = head;
    m_a_nxt    = $unsigned(-head);
    k_a_nxt    = req.index;
    last_a_nxt = req.last;
  end

  // Stage B: range flags, 32-bit saturation, leaky partial products and table index.
  always_comb begin
    vb_nxt     = va_r;
    neg_b_nxt  = s_a_r[AW-1];
    lo_b_nxt   = s_a_r < -(48'sd524288);
    hi_b_nxt   = s_a_r >= 48'sd524288;
    if (!s_a_r[AW-1] && (s_a_r[AW-2:31] != '0)) begin
      sat_b_nxt = 32'h7FFF_FFFF;
    end else if (s_a_r[AW-1] && (s_a_r[AW-2:31] != '1)) begin
      sat_b_nxt = 32'h8000_0000;
    end else begin
      sat_b_nxt = s_a_r[31:0];
    end
    pl_b_nxt   = 40'(m_a_r[23:0]) * 40'(cfg.gain);
    ph_b_nxt   = 40'(m_a_r[47:24]) * 40'(cfg.gain);
    u          = {~s_a_r[19], s_a_r[18:0]};
    sprod      = SPW'(u) * SPW'(SIG_N);
    idx_b_nxt  = sprod[20 +: SIW];
    k_b_nxt    = k_a_r;
    last_b_nxt = last_a_r;
  end

  // Output stage: finish the leaky product and select by activation kind.
  always_comb begin
    p = {ph_b_r, 24'd0} + 64'(pl_b_r) + 64'd65535;
    q = p[63:16];
    if (q > 48'h0000_8000_0000) begin
      leaky_v = 32'h8000_0000;
    end else begin
      leaky_v = 32'd0 - q[31:0];
    end
    if (lo_b_r) begin
      sig_v = 32'd0;
    end else if (hi_b_r) begin
      sig_v = 32'h0001_0000;
    end else begin
      sig_v = {16'd0, sig_rom[idx_b_r]};
    end
    case (cfg.kind)
      sdl_pkg::ACT_LINEAR:  val = sat_b_r;
      sdl_pkg::ACT_RELU:    val = neg_b_r ? 32'd0 : sat_b_r;
      sdl_pkg::ACT_SIGMOID: val = sig_v;
      sdl_pkg::ACT_LEAKY:   val = neg_b_r ? leaky_v : sat_b_r;
      default:              val = sat_b_r;
    endcase
    out_valid_nxt          = vb_r;
    out_item_nxt.out_index = k_b_r;
    out_item_nxt.out_value = $signed(val);
    out_item_nxt.last_out  = last_b_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r        <= 1'b0;
      vb_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      va_r        <= va_nxt;
      vb_r        <= vb_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_a_r      <= s_a_nxt;
      m_a_r      <= m_a_nxt;
      k_a_r      <= k_a_nxt;
      last_a_r   <= last_a_nxt;
      neg_b_r    <= neg_b_nxt;
      lo_b_r     <= lo_b_nxt;
      hi_b_r     <= hi_b_nxt;
      sat_b_r    <= sat_b_nxt;
      pl_b_r     <= pl_b_nxt;
      ph_b_r     <= ph_b_nxt;
      idx_b_r    <= idx_b_nxt;
      k_b_r      <= k_b_nxt;
      last_b_r   <= last_b_nxt;
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

`default_nettype wire
